// ----- src/hcbd_pkg.sv -----
package hcbd_pkg;

  // Width of the chunk size and byte counters
  localparam int SIZE_BITS = 32;

  // One raw body byte as it arrives
  typedef struct packed {
    logic [7:0] body_byte;
    logic       start_of_body;
  } in_word_t;

  // One decoded result
  typedef struct packed {
    logic       payload_valid;
    logic [7:0] payload_byte;
    logic       body_done;
    logic       format_error;
  } out_word_t;

endpackage

// ----- src/http_chunked_body_decoder.sv -----
// Chunked body decoder: takes one raw body byte per word and returns exactly one
// result word per byte (payload byte with its valid flag, plus sticky done and
// error flags). A byte is registered on input, run through the parser and held
// in the result register. Sustained rate is one byte per cycle while out_ready
// holds, set by the per-byte update of the parser state registers; both stages
// keep moving while the result register drains, and ready drops only when the
// result is stalled and the input stage is full.
module http_chunked_body_decoder (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  hcbd_pkg::in_word_t  in_word,
  output logic                out_valid,
  input  logic                out_ready,
  output hcbd_pkg::out_word_t out_word
);
  import hcbd_pkg::*;

  logic      in_q_valid;
  in_word_t  in_q;
  logic      advance;
  logic      step;
  out_word_t result;

  assign advance  = !out_valid || out_ready;
  assign step     = in_q_valid && advance;
  assign in_ready = !in_q_valid || advance;

  hcbd_parser u_parser (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .word   (in_q),
    .result (result)
  );

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (in_ready) begin
      in_q_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_q <= in_word;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_word <= result;
    end
  end

  // Done and error are exclusive
  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_word.body_done && out_word.format_error))
    else $error("done and error both set");

  // A payload byte never comes with a terminal flag
  a_payload_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_word.payload_valid) |->
      (!out_word.body_done && !out_word.format_error))
    else $error("payload word carries done or error");

  // Non-payload results carry a zero byte
  a_payload_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_word.payload_valid) |-> (out_word.payload_byte == 8'd0))
    else $error("payload byte not zero without payload");

  // An empty result stage never blocks the input
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result stage");

endmodule

// ----- src/hcbd_parser.sv -----
module hcbd_parser (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  hcbd_pkg::in_word_t  word,
  output hcbd_pkg::out_word_t result
);
  import hcbd_pkg::*;

  typedef enum logic [2:0] {
    PH_LEAD   = 3'd0,
    PH_DIGITS = 3'd1,
    PH_EXT    = 3'd2,
    PH_DATA   = 3'd3,
    PH_CR     = 3'd4,
    PH_LF     = 3'd5,
    PH_DONE   = 3'd6,
    PH_ERROR  = 3'd7
  } phase_t;

  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_LF  = 8'h0a;
  localparam logic [7:0] CH_VT  = 8'h0b;
  localparam logic [7:0] CH_FF  = 8'h0c;
  localparam logic [7:0] CH_CR  = 8'h0d;
  localparam logic [7:0] CH_SP  = 8'h20;

  phase_t               phase, phase_next;
  logic [SIZE_BITS-1:0] bytes_remaining, bytes_remaining_next;
  logic [SIZE_BITS-1:0] size_accum, size_accum_next;
  logic                 digit_seen, digit_seen_next;
  logic                 last_was_cr, last_was_cr_next;

  // State as seen by this byte, after an optional restart
  phase_t               cur_phase;
  logic [SIZE_BITS-1:0] cur_accum;
  logic                 cur_digit;
  logic                 cur_cr;

  logic [7:0]           c;
  logic                 hex_ok;
  logic [3:0]           hex_val;
  logic                 lead_space;
  logic                 overflow;
  logic [SIZE_BITS-1:0] bytes_dec;

  // Hex digit decode
  always_comb begin
    c       = word.body_byte;
    hex_ok  = 1'b0;
    hex_val = 4'd0;
    if (c >= "0" && c <= "9") begin
      hex_ok  = 1'b1;
      hex_val = 4'(c - 8'h30);
    end else if (c >= "a" && c <= "f") begin
      hex_ok  = 1'b1;
      hex_val = 4'(c - 8'h57);
    end else if (c >= "A" && c <= "F") begin
      hex_ok  = 1'b1;
      hex_val = 4'(c - 8'h37);
    end
    lead_space = (c == CH_SP) || (c == CH_TAB) || (c == CH_VT) ||
                 (c == CH_FF) || (c == CH_CR) || (c == CH_LF);
  end

  always_comb begin
    cur_phase = word.start_of_body ? PH_LEAD : phase;
    cur_accum = word.start_of_body ? '0 : size_accum;
    cur_digit = word.start_of_body ? 1'b0 : digit_seen;
    cur_cr    = word.start_of_body ? 1'b0 : last_was_cr;
    overflow  = (cur_accum[SIZE_BITS-1 -: 4] != 4'd0);
    bytes_dec = bytes_remaining - SIZE_BITS'(1);
  end

  // Per-byte state update
  always_comb begin
    logic eol;
    logic add;
    logic ext;
    eol = 1'b0;
    add = 1'b0;
    ext = 1'b0;
    phase_next           = cur_phase;
    bytes_remaining_next = bytes_remaining;
    size_accum_next      = cur_accum;
    digit_seen_next      = cur_digit;
    last_was_cr_next     = cur_cr;
    result               = '0;

    case (cur_phase)
      PH_LEAD: begin
        if (hex_ok) add = 1'b1;
        else if (c == CH_LF && cur_cr) eol = 1'b1;
        else if (lead_space) last_was_cr_next = (c == CH_CR);
        else phase_next = PH_ERROR;
      end
      PH_DIGITS: begin
        if (hex_ok) add = 1'b1;
        else ext = 1'b1;
      end
      PH_EXT: begin
        ext = 1'b1;
      end
      PH_DATA: begin
        result.payload_valid = 1'b1;
        result.payload_byte  = c;
        bytes_remaining_next = bytes_dec;
        if (bytes_dec == '0) phase_next = PH_CR;
      end
      PH_CR: begin
        phase_next = (c == CH_CR) ? PH_LF : PH_ERROR;
      end
      PH_LF: begin
        phase_next = (c == CH_LF) ? PH_LEAD : PH_ERROR;
      end
      default: begin
      end
    endcase

    // Text after the digits up to CR LF
    if (ext) begin
      phase_next = PH_EXT;
      if (c == CH_LF && cur_cr) eol = 1'b1;
      else last_was_cr_next = (c == CH_CR);
    end

    // Accumulate one hex digit, or fail on overflow
    if (add) begin
      if (overflow) begin
        phase_next = PH_ERROR;
      end else begin
        size_accum_next  = {cur_accum[SIZE_BITS-5:0], hex_val};
        digit_seen_next  = 1'b1;
        last_was_cr_next = 1'b0;
        phase_next       = PH_DIGITS;
      end
    end

    // Size line complete
    if (eol) begin
      if (!cur_digit) begin
        phase_next = PH_ERROR;
      end else if (cur_accum == '0) begin
        phase_next = PH_DONE;
      end else begin
        bytes_remaining_next = cur_accum;
        phase_next           = PH_DATA;
      end
      size_accum_next  = '0;
      digit_seen_next  = 1'b0;
      last_was_cr_next = 1'b0;
    end

    result.body_done    = (phase_next == PH_DONE);
    result.format_error = (phase_next == PH_ERROR);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_LEAD;
      bytes_remaining <= '0;
      size_accum      <= '0;
      digit_seen      <= 1'b0;
      last_was_cr     <= 1'b0;
    end else if (step) begin
      phase           <= phase_next;
      bytes_remaining <= bytes_remaining_next;
      size_accum      <= size_accum_next;
      digit_seen      <= digit_seen_next;
      last_was_cr     <= last_was_cr_next;
    end
  end

endmodule
